@@ hdl/wps_pkg.sv @@
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants for the RIFF/RIFX WAVE PCM16 stream parser.
// ----------------------------------------------------------------------------
package wps_pkg;

   // Four-character tags, first file byte in the top byte
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // fmt chunk checks
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
   localparam logic [15:0] FMT_PCM      = 16'd1;
   localparam logic [15:0] PCM_BITS     = 16'd16;
   localparam logic [4:0]  FMT_IDX_END  = 5'd16;

   // Default depth of the result queue
   localparam int WPS_QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      PH_MAGIC = 4'd0,
      PH_RSIZE = 4'd1,
      PH_WAVE  = 4'd2,
      PH_CID   = 4'd3,
      PH_CSIZE = 4'd4,
      PH_FMT   = 4'd5,
      PH_SKIP  = 4'd6,
      PH_PAD   = 4'd7,
      PH_DATA  = 4'd8,
      PH_IDLE  = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      CHUNK_OTHER = 2'd0,
      CHUNK_FMT   = 2'd1,
      CHUNK_DATA  = 2'd2
   } chunk_kind_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_ERROR  = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      FAULT_MAGIC      = 3'd0,
      FAULT_NOT_WAVE   = 3'd1,
      FAULT_MISSING    = 3'd2,
      FAULT_FORMAT     = 3'd3,
      FAULT_TRUNCATED  = 3'd4,
      FAULT_EARLY_DATA = 3'd5
   } fault_type;

   // One input beat
   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } item_type;

   // One result beat
   typedef struct packed {
      logic [1:0]         result_kind;
      logic [31:0]        sample_number;
      logic signed [15:0] sample_value;
      logic [31:0]        rate_hz;
      logic [2:0]         fault_code;
      logic               last_result;
   } rsp_type;

   // Results of one byte, in order: up to two
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

endpackage

@@ hdl/wps_in_stage.sv @@
// ----------------------------------------------------------------------------
// wps_in_stage
// Input register: holds one byte beat in front of the parser.
// ----------------------------------------------------------------------------
module wps_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_file_byte,
   input  logic              req_end_of_file,
   input  logic              take,
   output logic              item_valid,
   output wps_pkg::item_type item
);
   import wps_pkg::*;

   logic     vld_ff;
   item_type item_ff;

   // Free when empty or when the parser drains it this cycle
   assign req_ready  = !vld_ff || take;
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_ready) begin
         vld_ff <= req_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.file_byte   <= req_file_byte;
         item_ff.end_of_file <= req_end_of_file;
      end
   end

endmodule

@@ hdl/wps_parser.sv @@
// ----------------------------------------------------------------------------
// wps_parser
// Parse state and one-byte step: header, chunk walk, fmt fields, frames.
// ----------------------------------------------------------------------------
module wps_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  wps_pkg::item_type item,
   input  logic              room,
   input  logic [31:0]       sample_limit,
   output logic              take,
   output wps_pkg::push_type push
);
   import wps_pkg::*;

   phase_type      phase_ff, phase_in;
   logic [1:0]     byte_cnt_ff, byte_cnt_in;
   logic [31:0]    word_ff, word_in;
   logic [31:0]    chunk_len_ff, chunk_len_in;
   chunk_kind_type chunk_kind_ff, chunk_kind_in;
   logic           big_endian_ff, big_endian_in;
   logic           fmt_seen_ff, fmt_seen_in;
   logic [4:0]     fmt_idx_ff, fmt_idx_in;
   logic [15:0]    format_code_ff, format_code_in;
   logic [15:0]    channels_ff, channels_in;
   logic [15:0]    bits_ff, bits_in;
   logic [31:0]    rate_ff, rate_in;
   logic [16:0]    frame_pos_ff, frame_pos_in;
   logic [15:0]    left_ff, left_in;
   logic [7:0]     low_hold_ff, low_hold_in;
   logic [31:0]    sent_ff, sent_in;

   logic [7:0]     b;
   logic [31:0]    shifted;
   logic [31:0]    size_word;
   logic [31:0]    chunk_dec;
   logic [15:0]    word16;
   logic [16:0]    pair_sum;
   logic [16:0]    pair_adj;
   logic           frame_last;
   logic           emit_ok;
   logic           s_vld;
   logic           end_vld;
   result_kind_type end_kind;
   fault_type      end_fault;
   rsp_type        s_rsp;
   rsp_type        end_rsp;

   assign take = item_valid && room;

   // Byte-level helpers
   assign b         = item.file_byte;
   assign shifted   = {word_ff[23:0], b};
   assign size_word = big_endian_ff ? shifted : {b, word_ff[31:8]};
   assign chunk_dec = chunk_len_ff - 32'd1;
   assign word16    = big_endian_ff ? {low_hold_ff, b} : {b, low_hold_ff};
   // average of left and right, truncated toward zero
   assign pair_sum  = {left_ff[15], left_ff} + {word16[15], word16};
   assign pair_adj  = pair_sum + {16'd0, pair_sum[16]};
   assign frame_last = frame_pos_ff == {channels_ff - 16'd1, 1'b1};
   assign emit_ok   = (sample_limit == 32'd0) || (sent_ff < sample_limit);

   // Next state and results for one byte
   always_comb begin
      phase_in       = phase_ff;
      byte_cnt_in    = byte_cnt_ff;
      word_in        = word_ff;
      chunk_len_in   = chunk_len_ff;
      chunk_kind_in  = chunk_kind_ff;
      big_endian_in  = big_endian_ff;
      fmt_seen_in    = fmt_seen_ff;
      fmt_idx_in     = fmt_idx_ff;
      format_code_in = format_code_ff;
      channels_in    = channels_ff;
      bits_in        = bits_ff;
      rate_in        = rate_ff;
      frame_pos_in   = frame_pos_ff;
      left_in        = left_ff;
      low_hold_in    = low_hold_ff;
      sent_in        = sent_ff;
      s_vld          = 1'b0;
      end_vld        = 1'b0;
      end_kind       = KIND_ERROR;
      end_fault      = FAULT_MAGIC;
      s_rsp          = '0;
      end_rsp        = '0;

      case (phase_ff)
         PH_MAGIC: begin
            word_in     = shifted;
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               if (shifted == TAG_RIFF) begin
                  big_endian_in = 1'b0;
                  phase_in      = PH_RSIZE;
               end else if (shifted == TAG_RIFX) begin
                  big_endian_in = 1'b1;
                  phase_in      = PH_RSIZE;
               end else begin
                  end_vld   = 1'b1;
                  end_fault = FAULT_MAGIC;
                  phase_in  = PH_IDLE;
               end
            end
         end
         PH_RSIZE: begin
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               phase_in = PH_WAVE;
            end
         end
         PH_WAVE: begin
            word_in     = shifted;
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               if (shifted == TAG_WAVE) begin
                  phase_in = PH_CID;
               end else begin
                  end_vld   = 1'b1;
                  end_fault = FAULT_NOT_WAVE;
                  phase_in  = PH_IDLE;
               end
            end
         end
         PH_CID: begin
            word_in     = shifted;
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               if (shifted == TAG_FMT) begin
                  chunk_kind_in = CHUNK_FMT;
               end else if (shifted == TAG_DATA) begin
                  chunk_kind_in = CHUNK_DATA;
               end else begin
                  chunk_kind_in = CHUNK_OTHER;
               end
               phase_in = PH_CSIZE;
            end
         end
         PH_CSIZE: begin
            word_in     = size_word;
            byte_cnt_in = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               case (chunk_kind_ff)
                  CHUNK_FMT: begin
                     if (size_word < FMT_MIN_SIZE) begin
                        end_vld   = 1'b1;
                        end_fault = FAULT_FORMAT;
                        phase_in  = PH_IDLE;
                     end else begin
                        fmt_seen_in  = 1'b1;
                        fmt_idx_in   = 5'd0;
                        chunk_len_in = size_word;
                        phase_in     = PH_FMT;
                     end
                  end
                  CHUNK_DATA: begin
                     if (!fmt_seen_ff) begin
                        end_vld   = 1'b1;
                        end_fault = FAULT_EARLY_DATA;
                        phase_in  = PH_IDLE;
                     end else if (format_code_ff != FMT_PCM || bits_ff != PCM_BITS
                                  || channels_ff == 16'd0) begin
                        end_vld   = 1'b1;
                        end_fault = FAULT_FORMAT;
                        phase_in  = PH_IDLE;
                     end else if (size_word == 32'd0) begin
                        end_vld  = 1'b1;
                        end_kind = KIND_DONE;
                        phase_in = PH_IDLE;
                     end else begin
                        chunk_len_in = size_word;
                        frame_pos_in = 17'd0;
                        phase_in     = PH_DATA;
                     end
                  end
                  default: begin
                     chunk_len_in = size_word;
                     phase_in     = (size_word == 32'd0) ? PH_CID : PH_SKIP;
                  end
               endcase
            end
         end
         PH_FMT: begin
            // field bytes at fixed offsets, placed by byte order
            case (fmt_idx_ff)
               5'd0:  if (big_endian_ff) format_code_in[15:8] = b;
                      else format_code_in[7:0] = b;
               5'd1:  if (big_endian_ff) format_code_in[7:0] = b;
                      else format_code_in[15:8] = b;
               5'd2:  if (big_endian_ff) channels_in[15:8] = b;
                      else channels_in[7:0] = b;
               5'd3:  if (big_endian_ff) channels_in[7:0] = b;
                      else channels_in[15:8] = b;
               5'd4:  if (big_endian_ff) rate_in[31:24] = b;
                      else rate_in[7:0] = b;
               5'd5:  if (big_endian_ff) rate_in[23:16] = b;
                      else rate_in[15:8] = b;
               5'd6:  if (big_endian_ff) rate_in[15:8] = b;
                      else rate_in[23:16] = b;
               5'd7:  if (big_endian_ff) rate_in[7:0] = b;
                      else rate_in[31:24] = b;
               5'd14: if (big_endian_ff) bits_in[15:8] = b;
                      else bits_in[7:0] = b;
               5'd15: if (big_endian_ff) bits_in[7:0] = b;
                      else bits_in[15:8] = b;
               default: ;
            endcase
            if (fmt_idx_ff != FMT_IDX_END) begin
               fmt_idx_in = fmt_idx_ff + 5'd1;
            end
            chunk_len_in = chunk_dec;
            if (chunk_dec == 32'd0) begin
               phase_in = word_ff[0] ? PH_PAD : PH_CID;
            end
         end
         PH_SKIP: begin
            chunk_len_in = chunk_dec;
            if (chunk_dec == 32'd0) begin
               phase_in = word_ff[0] ? PH_PAD : PH_CID;
            end
         end
         PH_PAD: begin
            phase_in = PH_CID;
         end
         PH_DATA: begin
            // even byte held, odd byte completes a 16-bit word
            if (!frame_pos_ff[0]) begin
               low_hold_in = b;
            end else if (frame_pos_ff == 17'd1) begin
               left_in = word16;
            end else if (frame_pos_ff == 17'd3) begin
               left_in = pair_adj[16:1];
            end
            if (frame_last) begin
               if (emit_ok) begin
                  s_vld   = 1'b1;
                  sent_in = sent_ff + 32'd1;
               end
               frame_pos_in = 17'd0;
            end else begin
               frame_pos_in = frame_pos_ff + 17'd1;
            end
            chunk_len_in = chunk_dec;
            if (chunk_dec == 32'd0) begin
               end_vld  = 1'b1;
               end_kind = KIND_DONE;
               phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase

      // end of file before the parse is over
      if (item.end_of_file && phase_in != PH_IDLE) begin
         end_vld  = 1'b1;
         end_kind = KIND_ERROR;
         case (phase_in)
            PH_MAGIC: end_fault = FAULT_MAGIC;
            PH_RSIZE: end_fault = FAULT_NOT_WAVE;
            PH_WAVE:  end_fault = FAULT_NOT_WAVE;
            PH_DATA:  end_fault = FAULT_TRUNCATED;
            default:  end_fault = FAULT_MISSING;
         endcase
      end

      // result beats
      s_rsp.result_kind   = KIND_SAMPLE;
      s_rsp.sample_number = sent_ff;
      s_rsp.sample_value  = left_in;
      s_rsp.rate_hz       = rate_in;
      s_rsp.fault_code    = FAULT_MAGIC;
      s_rsp.last_result   = 1'b0;

      end_rsp.result_kind   = end_kind;
      end_rsp.sample_number = sent_in;
      end_rsp.sample_value  = 16'sd0;
      end_rsp.rate_hz       = rate_in;
      end_rsp.fault_code    = (end_kind == KIND_ERROR) ? end_fault : FAULT_MAGIC;
      end_rsp.last_result   = 1'b1;

      // new file after the last byte
      if (item.end_of_file) begin
         phase_in       = PH_MAGIC;
         byte_cnt_in    = 2'd0;
         word_in        = 32'd0;
         chunk_len_in   = 32'd0;
         chunk_kind_in  = CHUNK_OTHER;
         big_endian_in  = 1'b0;
         fmt_seen_in    = 1'b0;
         fmt_idx_in     = 5'd0;
         format_code_in = 16'd0;
         channels_in    = 16'd0;
         bits_in        = 16'd0;
         rate_in        = 32'd0;
         frame_pos_in   = 17'd0;
         left_in        = 16'd0;
         low_hold_in    = 8'd0;
         sent_in        = 32'd0;
      end
   end

   // Pack results in order: sample first, then done or error
   always_comb begin
      push.count = take ? ({1'b0, s_vld} + {1'b0, end_vld}) : 2'd0;
      push.slot0 = s_vld ? s_rsp : end_rsp;
      push.slot1 = end_rsp;
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         byte_cnt_ff    <= 2'd0;
         word_ff        <= 32'd0;
         chunk_len_ff   <= 32'd0;
         chunk_kind_ff  <= CHUNK_OTHER;
         big_endian_ff  <= 1'b0;
         fmt_seen_ff    <= 1'b0;
         fmt_idx_ff     <= 5'd0;
         format_code_ff <= 16'd0;
         channels_ff    <= 16'd0;
         bits_ff        <= 16'd0;
         rate_ff        <= 32'd0;
         frame_pos_ff   <= 17'd0;
         left_ff        <= 16'd0;
         low_hold_ff    <= 8'd0;
         sent_ff        <= 32'd0;
      end else if (take) begin
         phase_ff       <= phase_in;
         byte_cnt_ff    <= byte_cnt_in;
         word_ff        <= word_in;
         chunk_len_ff   <= chunk_len_in;
         chunk_kind_ff  <= chunk_kind_in;
         big_endian_ff  <= big_endian_in;
         fmt_seen_ff    <= fmt_seen_in;
         fmt_idx_ff     <= fmt_idx_in;
         format_code_ff <= format_code_in;
         channels_ff    <= channels_in;
         bits_ff        <= bits_in;
         rate_ff        <= rate_in;
         frame_pos_ff   <= frame_pos_in;
         left_ff        <= left_in;
         low_hold_ff    <= low_hold_in;
         sent_ff        <= sent_in;
      end
   end

endmodule

@@ hdl/wps_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// wps_rsp_queue
// Result queue: takes up to two beats per cycle, hands out one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module wps_rsp_queue #(
   parameter int DEPTH = wps_pkg::WPS_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  wps_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wps_pkg::rsp_type  rsp
);
   import wps_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

   rsp_type       mem [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] wr_next;
   logic          pop;

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      ptr_inc = (p == LAST_IDX) ? '0 : p + IW'(1);
   endfunction

   // Room for a full two-beat push without looking at this cycle's pop
   assign room      = count_ff <= ROOM_MAX;
   assign rsp_valid = count_ff != '0;
   assign rsp       = mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = ptr_inc(wr_ptr_ff);

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.slot1;
      end
   end

endmodule

@@ hdl/wav_pcm16_stream_parser_core.sv @@
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_core
// RIFF/RIFX WAVE parser, one file byte per beat, 16-bit PCM samples out.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register, then its parse step writes its
//   results into the result queue, which offers them on the rsp port.
// Throughput: one byte per cycle; a byte that closes the data with a sample
//   gives two beats, drained one per cycle while rsp_ready is high; input
//   stalls only while the queue holds more than QUEUE_DEPTH - 2 beats.
// Reset: synchronous; clears parse state, queue and sample_limit to zero.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_core #(
   parameter int QUEUE_DEPTH = wps_pkg::WPS_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_file_byte,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [31:0]        rsp_sample_number,
   output logic signed [15:0] rsp_sample_value,
   output logic [31:0]        rsp_rate_hz,
   output logic [2:0]         rsp_fault_code,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_sample_limit
);
   import wps_pkg::*;

   logic [31:0] sample_limit_ff;
   logic        item_valid;
   item_type    item;
   logic        take;
   logic        room;
   push_type    push;
   rsp_type     rsp;

   // Sample limit register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_limit_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         sample_limit_ff <= csr_sample_limit;
      end
   end

   wps_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_file_byte   (req_file_byte),
      .req_end_of_file (req_end_of_file),
      .take            (take),
      .item_valid      (item_valid),
      .item            (item)
   );

   wps_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .room         (room),
      .sample_limit (sample_limit_ff),
      .take         (take),
      .push         (push)
   );

   wps_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Result beat onto its ports
   assign rsp_result_kind   = rsp.result_kind;
   assign rsp_sample_number = rsp.sample_number;
   assign rsp_sample_value  = rsp.sample_value;
   assign rsp_rate_hz       = rsp.rate_hz;
   assign rsp_fault_code    = rsp.fault_code;
   assign rsp_last_result   = rsp.last_result;

endmodule

@@ hdl/wps_checker.sv @@
// ----------------------------------------------------------------------------
// wps_checker
// Port-level checks on the parser's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module wps_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_result_kind,
   input logic [31:0]        rsp_sample_number,
   input logic signed [15:0] rsp_sample_value,
   input logic [2:0]         rsp_fault_code,
   input logic               rsp_last_result
);
   import wps_pkg::*;

   // No result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A sample is never the last beat and carries no fault
   a_sample_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_SAMPLE)
         |-> (!rsp_last_result && rsp_fault_code == FAULT_MAGIC))
      else $error("sample beat with last or fault set");

   // Done and error close the file with a zero value
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != KIND_SAMPLE)
         |-> (rsp_last_result && rsp_sample_value == 16'sd0))
      else $error("end beat without last or with a value");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready)
         |=> (rsp_valid && $stable(rsp_sample_number) && $stable(rsp_result_kind)))
      else $error("result beat changed while stalled");

endmodule

bind wav_pcm16_stream_parser_core wps_checker u_wps_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_sample_number (rsp_sample_number),
   .rsp_sample_value  (rsp_sample_value),
   .rsp_fault_code    (rsp_fault_code),
   .rsp_last_result   (rsp_last_result)
);

@@ test/wav_pcm16_stream_parser_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_core_test
// Self-checking bench for the RIFF/RIFX WAVE PCM16 byte-stream parser.
// A short scripted run hits the header errors, then randomly built files
// (well-formed, damaged, cut short, plain noise) are streamed one byte per
// beat under several sample limits. A behavioral parser predicts every
// result beat, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_core_test;
   import wps_pkg::*;

   localparam int SCRIPT_ROWS  = 24;
   localparam int ITEM_TARGET  = 1450;
   localparam int PLAN_STEPS   = 5;
   localparam int PHASE_BYTES  = ITEM_TARGET / PLAN_STEPS;
   localparam int QUIET_TAIL   = 4;
   localparam int STALL_LIMIT  = 1000;

   // fault field reads zero outside error results
   localparam fault_type NO_FAULT = FAULT_MAGIC;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_file_byte = 8'd0;
   logic               req_end_of_file = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic [31:0]        rsp_sample_number;
   logic signed [15:0] rsp_sample_value;
   logic [31:0]        rsp_rate_hz;
   logic [2:0]         rsp_fault_code;
   logic               rsp_last_result;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [31:0]        csr_sample_limit = 32'd0;

   wav_pcm16_stream_parser_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_file_byte     (req_file_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_sample_number (rsp_sample_number),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_rate_hz       (rsp_rate_hz),
      .rsp_fault_code    (rsp_fault_code),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sample_limit  (csr_sample_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Behavioral parser: mirrored state and result bookkeeping
   // ---------------------------------------------------------------------
   phase_type      phase = PH_MAGIC;
   logic [2:0]     word_bytes = 3'd0;
   logic [31:0]    shreg = 32'd0;
   logic [31:0]    chunk_left = 32'd0;
   chunk_kind_type chunk_kind = CHUNK_OTHER;
   logic           is_rifx = 1'b0;
   logic           fmt_seen = 1'b0;
   logic [15:0]    fmt_tag = 16'd0;
   logic [15:0]    num_channels = 16'd0;
   logic [15:0]    bits = 16'd0;
   logic [31:0]    rate = 32'd0;
   logic [16:0]    frame_pos = 17'd0;
   logic [15:0]    mix_sample = 16'd0;
   logic [7:0]     held_byte = 8'd0;
   logic [31:0]    emitted = 32'd0;
   logic [31:0]    limit_samples = 32'd0;

   rsp_type step_out[$];      // results of the byte being parsed
   rsp_type results_due[$];   // results not yet seen on the rsp port
   int      mismatches = 0;
   int      counted_bytes = 0;

   function automatic void clear_parse();
      phase = PH_MAGIC;
      word_bytes = 3'd0;
      shreg = 32'd0;
      chunk_left = 32'd0;
      chunk_kind = CHUNK_OTHER;
      is_rifx = 1'b0;
      fmt_seen = 1'b0;
      fmt_tag = 16'd0;
      num_channels = 16'd0;
      bits = 16'd0;
      rate = 32'd0;
      frame_pos = 17'd0;
      mix_sample = 16'd0;
      held_byte = 8'd0;
      emitted = 32'd0;
   endfunction

   function automatic void emit(input result_kind_type kind, input logic [31:0] num,
                                input logic [15:0] val, input fault_type fault);
      rsp_type r;
      r.result_kind   = kind;
      r.sample_number = num;
      r.sample_value  = val;
      r.rate_hz       = rate;
      r.fault_code    = fault;
      r.last_result   = (kind != KIND_SAMPLE);
      step_out.push_back(r);
   endfunction

   function automatic void abort(input fault_type fault);
      emit(KIND_ERROR, emitted, 16'd0, fault);
      phase = PH_IDLE;
   endfunction

   function automatic void wrap_up();
      emit(KIND_DONE, emitted, 16'd0, NO_FAULT);
      phase = PH_IDLE;
   endfunction

   // Tag bytes arrive first byte on top; true once four are in
   function automatic logic shift_in(input logic [7:0] b);
      logic full;
      shreg = {shreg[23:0], b};
      word_bytes = word_bytes + 3'd1;
      full = (word_bytes == 3'd4);
      if (full)
         word_bytes = 3'd0;
      return full;
   endfunction

   // Byte k of a width-byte field, honoring the file's byte order
   function automatic logic [31:0] place_byte(input logic [31:0] cur, input int k,
                                              input int width, input logic [7:0] b);
      logic [31:0] merged;
      int          sh;
      sh = is_rifx ? 8 * (width - 1 - k) : 8 * k;
      merged = cur;
      merged[sh +: 8] = b;
      return merged;
   endfunction

   function automatic void end_body();
      phase = shreg[0] ? PH_PAD : PH_CID;
   endfunction

   // Chunk size complete: decide on fmt, data or skip
   function automatic void size_read();
      case (chunk_kind)
         CHUNK_FMT: begin
            if (shreg < FMT_MIN_SIZE) begin
               abort(FAULT_FORMAT);
            end else begin
               fmt_seen = 1'b1;
               chunk_left = shreg;
               phase = PH_FMT;
            end
         end
         CHUNK_DATA: begin
            if (!fmt_seen)
               abort(FAULT_EARLY_DATA);
            else if (fmt_tag != FMT_PCM || bits != PCM_BITS || num_channels == 16'd0)
               abort(FAULT_FORMAT);
            else if (shreg == 32'd0)
               wrap_up();
            else begin
               chunk_left = shreg;
               frame_pos = 17'd0;
               phase = PH_DATA;
            end
         end
         default: begin
            chunk_left = shreg;
            phase = (shreg == 32'd0) ? PH_CID : PH_SKIP;
         end
      endcase
   endfunction

   function automatic void take_fmt_byte(input logic [7:0] b);
      logic [31:0] idx;
      idx = shreg - chunk_left;
      if (idx < 2)
         fmt_tag = 16'(place_byte({16'd0, fmt_tag}, int'(idx), 2, b));
      else if (idx < 4)
         num_channels = 16'(place_byte({16'd0, num_channels}, int'(idx) - 2, 2, b));
      else if (idx < 8)
         rate = place_byte(rate, int'(idx) - 4, 4, b);
      else if (idx >= 14 && idx < 16)
         bits = 16'(place_byte({16'd0, bits}, int'(idx) - 14, 2, b));
   endfunction

   // Frame assembly: left sample kept, second channel averaged in
   function automatic void take_sample_byte(input logic [7:0] b);
      logic [31:0] frame_size;
      logic [15:0] word;
      int          l;
      int          r;
      int          avg;
      frame_size = 2 * {16'd0, num_channels};
      if (!frame_pos[0]) begin
         held_byte = b;
      end else begin
         word = is_rifx ? {held_byte, b} : {b, held_byte};
         if (frame_pos == 17'd1) begin
            mix_sample = word;
         end else if (frame_pos == 17'd3) begin
            l = int'($signed(mix_sample));
            r = int'($signed(word));
            avg = (l + r) / 2;
            mix_sample = avg[15:0];
         end
      end
      if ({15'd0, frame_pos} == frame_size - 1) begin
         if (limit_samples == 32'd0 || emitted < limit_samples) begin
            emit(KIND_SAMPLE, emitted, mix_sample, NO_FAULT);
            emitted = emitted + 1;
         end
         frame_pos = 17'd0;
      end else begin
         frame_pos = frame_pos + 17'd1;
      end
      chunk_left = chunk_left - 1;
      if (chunk_left == 32'd0)
         wrap_up();
   endfunction

   // One file byte through the parser; results land in step_out
   function automatic void parse_byte(input logic [7:0] b, input logic eof);
      case (phase)
         PH_MAGIC: begin
            if (shift_in(b)) begin
               if (shreg == TAG_RIFF) begin
                  is_rifx = 1'b0;
                  phase = PH_RSIZE;
               end else if (shreg == TAG_RIFX) begin
                  is_rifx = 1'b1;
                  phase = PH_RSIZE;
               end else begin
                  abort(FAULT_MAGIC);
               end
            end
         end
         PH_RSIZE: begin
            word_bytes = word_bytes + 3'd1;
            if (word_bytes == 3'd4) begin
               word_bytes = 3'd0;
               phase = PH_WAVE;
            end
         end
         PH_WAVE: begin
            if (shift_in(b)) begin
               if (shreg == TAG_WAVE)
                  phase = PH_CID;
               else
                  abort(FAULT_NOT_WAVE);
            end
         end
         PH_CID: begin
            if (shift_in(b)) begin
               chunk_kind = (shreg == TAG_FMT) ? CHUNK_FMT
                          : (shreg == TAG_DATA) ? CHUNK_DATA : CHUNK_OTHER;
               phase = PH_CSIZE;
            end
         end
         PH_CSIZE: begin
            shreg = is_rifx ? {shreg[23:0], b} : {b, shreg[31:8]};
            word_bytes = word_bytes + 3'd1;
            if (word_bytes == 3'd4) begin
               word_bytes = 3'd0;
               size_read();
            end
         end
         PH_FMT: begin
            take_fmt_byte(b);
            chunk_left = chunk_left - 1;
            if (chunk_left == 32'd0)
               end_body();
         end
         PH_SKIP: begin
            chunk_left = chunk_left - 1;
            if (chunk_left == 32'd0)
               end_body();
         end
         PH_PAD: phase = PH_CID;
         PH_DATA: take_sample_byte(b);
         default: ;
      endcase

      // end of file: report where the file stopped, then start over
      if (eof) begin
         case (phase)
            PH_IDLE: ;
            PH_MAGIC: abort(FAULT_MAGIC);
            PH_RSIZE, PH_WAVE: abort(FAULT_NOT_WAVE);
            PH_DATA: abort(FAULT_TRUNCATED);
            default: abort(FAULT_MISSING);
         endcase
         clear_parse();
      end
   endfunction

   // ---------------------------------------------------------------------
   // File builder
   // ---------------------------------------------------------------------
   logic [7:0]  file_bytes[$];
   logic        build_be = 1'b0;
   logic [15:0] file_chans = 16'd1;

   function automatic void put_tag(input logic [31:0] t);
      for (int i = 3; i >= 0; i--)
         file_bytes.push_back(t[8 * i +: 8]);
   endfunction

   function automatic void put_field(input logic [31:0] v, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         file_bytes.push_back(build_be ? v[8 * (nbytes - 1 - i) +: 8] : v[8 * i +: 8]);
   endfunction

   // Sample bytes lean toward the 16-bit extremes
   function automatic logic [7:0] pick_sample_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void put_other_chunk();
      logic [31:0] size;
      int          body;
      size = $urandom_range(0, 9);
      body = size;
      if ($urandom_range(0, 19) == 0)
         size = $urandom | 32'h0100_0000;
      put_tag($urandom);
      put_field(size, 4);
      repeat (body) file_bytes.push_back(8'($urandom));
      if (size[0])
         file_bytes.push_back(8'($urandom));
   endfunction

   function automatic void put_fmt();
      logic [31:0] size;
      logic [15:0] tag;
      logic [15:0] chans;
      logic [15:0] bps;
      if ($urandom_range(0, 9) == 0)
         size = $urandom_range(0, 15);
      else if ($urandom_range(0, 3) == 0)
         size = 16 + $urandom_range(1, 5);
      else
         size = 16;
      tag = ($urandom_range(0, 7) == 0) ? 16'($urandom) : FMT_PCM;
      bps = ($urandom_range(0, 7) == 0) ? 16'($urandom) : PCM_BITS;
      case ($urandom_range(0, 11))
         0: chans = 16'd0;
         1: chans = 16'hFFFF;
         2, 3: chans = 16'($urandom_range(3, 4));
         4, 5, 6: chans = 16'd2;
         default: chans = 16'd1;
      endcase
      file_chans = chans;
      put_tag(TAG_FMT);
      put_field(size, 4);
      if (size < 16) begin
         repeat (size) file_bytes.push_back(8'($urandom));
      end else begin
         put_field({16'd0, tag}, 2);
         put_field({16'd0, chans}, 2);
         put_field($urandom, 4);
         put_field($urandom, 4);
         put_field($urandom, 2);
         put_field({16'd0, bps}, 2);
         repeat (size - 16) file_bytes.push_back(8'($urandom));
      end
      if (size[0])
         file_bytes.push_back(8'($urandom));
   endfunction

   function automatic void put_data();
      logic [31:0] size;
      logic [31:0] fsz;
      logic [31:0] body;
      int          frames;
      fsz = (file_chans == 16'd0 || file_chans > 16'd4) ? 32'd2 : 2 * {16'd0, file_chans};
      frames = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
      size = frames * fsz;
      if (file_chans > 16'd4)
         size = $urandom_range(1, 20);
      else if ($urandom_range(0, 4) == 0)
         size = size + $urandom_range(1, fsz - 1);
      body = size;
      // a huge size that the file never fills
      if ($urandom_range(0, 19) == 0)
         size = 32'hFFFF_FF00 | $urandom_range(0, 255);
      put_tag(TAG_DATA);
      put_field(size, 4);
      repeat (body) file_bytes.push_back(pick_sample_byte());
   endfunction

   function automatic void build_file();
      int keep;
      file_bytes.delete();
      file_chans = 16'd1;
      if ($urandom_range(0, 24) == 0) begin
         repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom));
      end else begin
         build_be = 1'($urandom_range(0, 1));
         put_tag(build_be ? TAG_RIFX : TAG_RIFF);
         put_field($urandom, 4);
         put_tag(TAG_WAVE);
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) put_other_chunk();
         if ($urandom_range(0, 15) == 0)
            put_data();
         put_fmt();
         if ($urandom_range(0, 9) == 0)
            put_fmt();
         if ($urandom_range(0, 4) == 0)
            put_other_chunk();
         if ($urandom_range(0, 15) != 0)
            put_data();
         repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
         // damage: one flipped byte, or an early end of file
         if ($urandom_range(0, 9) == 0)
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
         if ($urandom_range(0, 7) == 0) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
               file_bytes.delete(file_bytes.size() - 1);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Byte sender, register writes, drain
   // ---------------------------------------------------------------------
   logic sender_burst = 1'b0;

   task automatic send_byte(input logic [7:0] b, input logic eof, input logic pinned,
                            input rsp_type pinned_result);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_file_byte   <= b;
      req_end_of_file <= eof;
      do @(posedge clock); while (!req_ready);
      counted_bytes++;
      step_out.delete();
      parse_byte(b, eof);
      if (pinned) begin
         step_out.delete();
         step_out.push_back(pinned_result);
      end
      foreach (step_out[i])
         results_due.push_back(step_out[i]);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      csr_valid        <= 1'b1;
      csr_sample_limit <= value;
      do @(posedge clock); while (!csr_ready);
      limit_samples = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold off input until every pending result is out, plus pipeline slack
   task automatic settle();
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(negedge clock);
      repeat (QUIET_TAIL) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready stalls and checking
   // ---------------------------------------------------------------------
   int   rsp_hold = 0;
   logic rsp_burst = 1'b0;

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $error("result beat with nothing pending: kind %0d, number %0d",
                   rsp_result_kind, rsp_sample_number);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            if (rsp_result_kind !== want.result_kind) begin
               $error("rsp_result_kind: expected %0d, got %0d",
                      want.result_kind, rsp_result_kind);
               mismatches++;
            end
            if (rsp_sample_number !== want.sample_number) begin
               $error("rsp_sample_number: expected %0d, got %0d",
                      want.sample_number, rsp_sample_number);
               mismatches++;
            end
            if (rsp_sample_value !== want.sample_value) begin
               $error("rsp_sample_value: expected %0d, got %0d",
                      $signed(want.sample_value), rsp_sample_value);
               mismatches++;
            end
            if (rsp_rate_hz !== want.rate_hz) begin
               $error("rsp_rate_hz: expected %0d, got %0d", want.rate_hz, rsp_rate_hz);
               mismatches++;
            end
            if (rsp_fault_code !== want.fault_code) begin
               $error("rsp_fault_code: expected %0d, got %0d",
                      want.fault_code, rsp_fault_code);
               mismatches++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("rsp_last_result: expected %0d, got %0d",
                      want.last_result, rsp_last_result);
               mismatches++;
            end
         end
         // next stall; now and then switch between stalling and streaming
         if ($urandom_range(0, 15) == 0)
            rsp_burst = !rsp_burst;
         rsp_hold = rsp_burst ? 0 : $urandom_range(0, 18);
      end
   end

   // Ends the run when no beat moves on any channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [7:0]      value;
      logic            last_byte;
      logic            pinned;
      result_kind_type kind;
      fault_type       fault;
   } script_row_type;

   // Header errors; pinned rows carry their one result, with nothing counted yet
   script_row_type opening_script [SCRIPT_ROWS] = '{
      '{"X",   1'b1, 1'b1, KIND_ERROR,  FAULT_MAGIC},     // file ends inside the magic
      '{"R",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"I",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"F",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'hFF, 1'b0, 1'b1, KIND_ERROR,  FAULT_MAGIC},     // bad magic word
      '{8'h00, 1'b1, 1'b0, KIND_SAMPLE, NO_FAULT},        // ignored, closes file
      '{"R",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"I",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"F",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"F",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'hFF, 1'b1, 1'b1, KIND_ERROR,  FAULT_NOT_WAVE},  // ends inside RIFF size
      '{"R",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"I",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"F",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"X",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'hFF, 1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'hFF, 1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'hFF, 1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'hFF, 1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"W",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"A",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{"V",   1'b0, 1'b0, KIND_SAMPLE, NO_FAULT},
      '{8'h00, 1'b0, 1'b1, KIND_ERROR,  FAULT_NOT_WAVE},  // WAVE word wrong
      '{8'h00, 1'b1, 1'b0, KIND_SAMPLE, NO_FAULT}         // ignored, closes file
   };

   // Sample limit per random phase; one slot is drawn at run time
   logic [31:0] limit_plan [PLAN_STEPS] = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd0};

   initial begin : stimulus
      rsp_type pinned_rec;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_limit(32'd0);

      // scripted header errors
      sender_burst = 1'b0;
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         pinned_rec.result_kind   = opening_script[i].kind;
         pinned_rec.sample_number = 32'd0;
         pinned_rec.sample_value  = 16'sd0;
         pinned_rec.rate_hz       = 32'd0;
         pinned_rec.fault_code    = opening_script[i].fault;
         pinned_rec.last_result   = 1'b1;
         send_byte(opening_script[i].value, opening_script[i].last_byte,
                   opening_script[i].pinned, pinned_rec);
      end
      settle();

      // random files, one sample limit per phase
      limit_plan[3] = $urandom_range(3, 9);
      for (int p = 0; p < PLAN_STEPS; p++) begin
         write_limit(limit_plan[p]);
         while (counted_bytes < (p + 1) * PHASE_BYTES) begin
            build_file();
            sender_burst = ($urandom_range(0, 3) == 0);
            foreach (file_bytes[i])
               send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, pinned_rec);
            if ($urandom_range(0, 7) == 0)
               settle();
         end
         settle();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
